// File: src/bm2_pkg.sv
// Shared constants, types and the window function of the 2x2 morphology block.
`timescale 1ns / 1ps
package bm2_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_ROWS = 2'd2;

	localparam int CFG_W  = 11;
	localparam int IDX_W  = 2;
	localparam int PIX_W  = 8;
	// Wide enough to compare an 11-bit size against a bound of up to 4096
	localparam int SZ_W   = 13;

	localparam logic MODE_DILATE = 1'b0;
	localparam logic MODE_ERODE  = 1'b1;

	localparam logic [PIX_W-1:0] PIX_HIGH = 8'd255;
	localparam logic [PIX_W-1:0] PIX_LOW  = 8'd0;

	localparam logic [CFG_W-1:0] COLS_RESET = 11'd321;
	localparam logic [CFG_W-1:0] ROWS_RESET = 11'd231;

	typedef logic [PIX_W-1:0] pixel_t;

	// Per-item control from the raster counters to the window stage
	typedef struct packed {
		logic emit;
		logic last;
	} scan_info_t;

	function automatic pixel_t window_result(logic mode, pixel_t a, pixel_t b,
			pixel_t c, pixel_t d);
		pixel_t res;
		if (mode == MODE_DILATE) begin
			res = (a == PIX_HIGH || b == PIX_HIGH || c == PIX_HIGH || d == PIX_HIGH)
				? PIX_HIGH : PIX_LOW;
		end else begin
			res = (a == PIX_LOW || b == PIX_LOW || c == PIX_LOW || d == PIX_LOW)
				? PIX_LOW : PIX_HIGH;
		end
		return res;
	endfunction

endpackage

// File: src/bm2_pix_if.sv
// Input pixel channel: valid/ready handshake carrying one grey pixel.
`timescale 1ns / 1ps
interface bm2_pix_if;
	logic                      valid;
	logic                      ready;
	logic [bm2_pkg::PIX_W-1:0] pixel_in;

	modport source (output valid, output pixel_in, input ready);
	modport sink   (input valid, input pixel_in, output ready);
endinterface

// File: src/bm2_res_if.sv
// Result channel: valid/ready handshake carrying one result pixel and its last flag.
`timescale 1ns / 1ps
interface bm2_res_if;
	logic                      valid;
	logic                      ready;
	logic [bm2_pkg::PIX_W-1:0] pixel_out;
	logic                      last_out;

	modport source (output valid, output pixel_out, output last_out, input ready);
	modport sink   (input valid, input pixel_out, input last_out, output ready);
endinterface

// File: src/bm2_line_buf.sv
// Line buffer: read-first synchronous memory holding the previous image row.
`timescale 1ns / 1ps
module bm2_line_buf #(
	parameter int DEPTH  = 1024,
	parameter int ADDR_W = 10
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [ADDR_W-1:0]    addr,
	input  bm2_pkg::pixel_t      wdata,
	output bm2_pkg::pixel_t      rdata
);

	bm2_pkg::pixel_t mem [DEPTH];
	bm2_pkg::pixel_t rdata_q;

	// Return the old entry and replace it with the new pixel in the same cycle
	always_ff @(posedge clk) begin
		if (we) begin
			rdata_q    <= mem[addr];
			mem[addr]  <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

// File: src/bm2_scan.sv
// Raster position counters with size clamping and per-item emit/last decode.
`timescale 1ns / 1ps
module bm2_scan #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024,
	parameter int COL_W    = 10,
	parameter int ROW_W    = 10
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        advance,
	input  logic [bm2_pkg::CFG_W-1:0]   image_cols,
	input  logic [bm2_pkg::CFG_W-1:0]   image_rows,
	output logic [COL_W-1:0]            col,
	output bm2_pkg::scan_info_t         info
);

	logic [bm2_pkg::SZ_W-1:0] cols_x, rows_x, cols_c, rows_c;
	logic [COL_W-1:0]         cols_m1, col_q;
	logic [ROW_W-1:0]         rows_m1, row_q;
	logic                     last_col, last_row;

	assign cols_x = bm2_pkg::SZ_W'(image_cols);
	assign rows_x = bm2_pkg::SZ_W'(image_rows);

	always_comb begin
		if (cols_x < bm2_pkg::SZ_W'(2))
			cols_c = bm2_pkg::SZ_W'(2);
		else if (cols_x > bm2_pkg::SZ_W'(MAX_COLS))
			cols_c = bm2_pkg::SZ_W'(MAX_COLS);
		else
			cols_c = cols_x;
		if (rows_x < bm2_pkg::SZ_W'(2))
			rows_c = bm2_pkg::SZ_W'(2);
		else if (rows_x > bm2_pkg::SZ_W'(MAX_ROWS))
			rows_c = bm2_pkg::SZ_W'(MAX_ROWS);
		else
			rows_c = rows_x;
	end

	assign cols_m1 = COL_W'(cols_c - bm2_pkg::SZ_W'(1));
	assign rows_m1 = ROW_W'(rows_c - bm2_pkg::SZ_W'(1));

	// At or beyond the last position wraps, so a shrink mid-image recovers
	assign last_col = (col_q >= cols_m1);
	assign last_row = (row_q >= rows_m1);

	assign col       = col_q;
	assign info.emit = (col_q != '0) && (row_q != '0);
	assign info.last = (col_q == cols_m1) && (row_q == rows_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

// File: src/bm2_window.sv
// Window stage: joins line-buffer data with the held neighbours and drives the result register.
`timescale 1ns / 1ps
module bm2_window (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  bm2_pkg::pixel_t       pixel,
	input  bm2_pkg::scan_info_t   info,
	input  bm2_pkg::pixel_t       upper,
	input  logic                  mode,
	output logic                  free,
	bm2_res_if.source             results
);

	logic                valid_s1;
	bm2_pkg::pixel_t     pix_s1, lower_s1;
	bm2_pkg::scan_info_t info_s1;
	bm2_pkg::pixel_t     prev_lower_q, prev_upper_q;
	logic                out_valid_q;
	bm2_pkg::pixel_t     out_pix_q;
	logic                out_last_q;
	logic                advance;

	assign advance = valid_s1 && (!out_valid_q || results.ready);
	assign free    = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			out_valid_q  <= 1'b0;
			prev_lower_q <= bm2_pkg::PIX_LOW;
			prev_upper_q <= bm2_pkg::PIX_LOW;
		end else begin
			if (accept) begin
				valid_s1     <= 1'b1;
				prev_lower_q <= pixel;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			// The line-buffer word of this item is the upper-left of the next
			if (advance)
				prev_upper_q <= upper;
			if (advance && info_s1.emit)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1   <= pixel;
			lower_s1 <= prev_lower_q;
			info_s1  <= info;
		end
		if (advance && info_s1.emit) begin
			out_pix_q  <= bm2_pkg::window_result(mode, prev_upper_q, upper, lower_s1, pix_s1);
			out_last_q <= info_s1.last;
		end
	end

	assign results.valid     = out_valid_q;
	assign results.pixel_out = out_pix_q;
	assign results.last_out  = out_last_q;

endmodule

// File: src/binary_morphology_2x2.sv
// Top level of the 2x2 binary morphology block.
//
// Pixels enter on the 'pixels' channel in raster order, one item per accepted
// valid/ready handshake. Each accepted pixel (r,c) with r and c non-zero yields
// one item on the 'results' channel: the dilation or erosion of the 2x2 window
// whose origin is (r-1,c-1), with last_out set on the final window of the image.
// Pixels of the first row and first column yield no item.
// Sizes and mode are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while idle, which the block does not enforce; sizes are clamped
// to [2, MAX_COLS] and [2, MAX_ROWS]. Each pixel passes the window stage and then
// the result register before result valid rises. One pixel is taken every cycle
// while the receiver keeps up: the line buffer is a single-port memory read and
// written at the same address in the same cycle. When the receiver stalls, the
// result register and the window stage hold and 'pixels.ready' drops once both
// are full; nothing is dropped. Reset clears counters, neighbour registers and
// the pipeline at once; no clearing pass runs and the line buffer contents are
// don't-care until the first row is written.
`timescale 1ns / 1ps
module binary_morphology_2x2 #(
	parameter int MAX_COLS = 1024,
	parameter int MAX_ROWS = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [bm2_pkg::IDX_W-1:0]     cfg_index,
	input  logic [bm2_pkg::CFG_W-1:0]     cfg_data,
	bm2_pix_if.sink                       pixels,
	bm2_res_if.source                     results
);

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int ROW_W = $clog2(MAX_ROWS);

	logic                      mode_q;
	logic [bm2_pkg::CFG_W-1:0] cols_q, rows_q;
	logic                      accept, free;
	logic [COL_W-1:0]          col;
	bm2_pkg::scan_info_t       info;
	bm2_pkg::pixel_t           upper;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= bm2_pkg::MODE_DILATE;
			cols_q <= bm2_pkg::COLS_RESET;
			rows_q <= bm2_pkg::ROWS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bm2_pkg::REG_MODE: mode_q <= cfg_data[0];
				bm2_pkg::REG_COLS: cols_q <= cfg_data;
				bm2_pkg::REG_ROWS: rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign pixels.ready = free;
	assign accept       = pixels.valid && free;

	bm2_scan #(
		.MAX_COLS (MAX_COLS),
		.MAX_ROWS (MAX_ROWS),
		.COL_W    (COL_W),
		.ROW_W    (ROW_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (accept),
		.image_cols (cols_q),
		.image_rows (rows_q),
		.col        (col),
		.info       (info)
	);

	bm2_line_buf #(
		.DEPTH  (MAX_COLS),
		.ADDR_W (COL_W)
	) u_line_buf (
		.clk   (clk),
		.we    (accept),
		.addr  (col),
		.wdata (pixels.pixel_in),
		.rdata (upper)
	);

	bm2_window u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.pixel   (pixels.pixel_in),
		.info    (info),
		.upper   (upper),
		.mode    (mode_q),
		.free    (free),
		.results (results)
	);

	a_binary_out: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (results.pixel_out == bm2_pkg::PIX_HIGH ||
			results.pixel_out == bm2_pkg::PIX_LOW))
		else $error("result pixel is not binary");

	a_ready_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		!results.valid |-> pixels.ready)
		else $error("input stalled with an empty result register");

	// The item ahead may raise valid; check as this pixel leaves the window stage
	a_first_col_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && col == '0) |-> ##2 !$rose(results.valid))
		else $error("first-column pixel produced a result");

endmodule

// File: tb/tb_binary_morphology_2x2.sv
// Self-checking testbench for the 2x2 binary morphology block.
`timescale 1ns / 1ps
module tb_binary_morphology_2x2;

	localparam int LINE_MAX = 1024;
	localparam int ROWS_MAX = 1024;

	typedef struct {
		bm2_pkg::pixel_t pix;
		logic            last;
	} window_res_t;

	typedef enum int {
		STYLE_BINARY,
		STYLE_MOSTLY_HIGH,
		STYLE_MOSTLY_LOW,
		STYLE_GREY
	} pixel_style_t;

	logic                      clk;
	logic                      arst_n;
	logic                      cfg_we;
	logic [bm2_pkg::IDX_W-1:0] cfg_index;
	logic [bm2_pkg::CFG_W-1:0] cfg_data;

	bm2_pix_if pix_ch ();
	bm2_res_if res_ch ();

	binary_morphology_2x2 #(
		.MAX_COLS(LINE_MAX),
		.MAX_ROWS(ROWS_MAX)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pixels   (pix_ch),
		.results  (res_ch)
	);

	// Raster state and settings as the block should hold them
	bm2_pkg::pixel_t           line_buf [LINE_MAX];
	int                        line_filled = 0;
	bm2_pkg::pixel_t           upper_left = bm2_pkg::PIX_LOW;
	bm2_pkg::pixel_t           lower_left = bm2_pkg::PIX_LOW;
	int                        scan_col = 0;
	int                        scan_row = 0;
	logic                      cfg_erode = bm2_pkg::MODE_DILATE;
	logic [bm2_pkg::CFG_W-1:0] cfg_cols = bm2_pkg::COLS_RESET;
	logic [bm2_pkg::CFG_W-1:0] cfg_rows = bm2_pkg::ROWS_RESET;

	window_res_t pending_windows [$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;
	int hold_seq = 0;
	int hold_seen = 0;
	int hold_left = 0;

	int pixels_sent = 0;
	int windows_checked = 0;
	int image_ends = 0;
	int stall_cycles = 0;
	int fault_count = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#(5_000_000);
		$display("tb_binary_morphology_2x2 failed");
		$finish;
	end

	function automatic int clamp_size(input int v, input int hi);
		if (v < 2) return 2;
		if (v > hi) return hi;
		return v;
	endfunction

	function automatic bm2_pkg::pixel_t morph_window(input logic erode,
			input bm2_pkg::pixel_t a, input bm2_pkg::pixel_t b,
			input bm2_pkg::pixel_t c, input bm2_pkg::pixel_t d);
		int n_high;
		int n_low;
		n_high = (a == bm2_pkg::PIX_HIGH) + (b == bm2_pkg::PIX_HIGH)
			+ (c == bm2_pkg::PIX_HIGH) + (d == bm2_pkg::PIX_HIGH);
		n_low  = (a == bm2_pkg::PIX_LOW) + (b == bm2_pkg::PIX_LOW)
			+ (c == bm2_pkg::PIX_LOW) + (d == bm2_pkg::PIX_LOW);
		if (erode == bm2_pkg::MODE_ERODE)
			return (n_low != 0) ? bm2_pkg::PIX_LOW : bm2_pkg::PIX_HIGH;
		return (n_high != 0) ? bm2_pkg::PIX_HIGH : bm2_pkg::PIX_LOW;
	endfunction

	// Advance the raster by one accepted pixel and queue the window it completes
	function automatic void step_raster_window(input bm2_pkg::pixel_t px);
		int              cols_eff;
		int              rows_eff;
		bm2_pkg::pixel_t above;
		window_res_t     w;
		cols_eff = clamp_size(int'(cfg_cols), LINE_MAX);
		rows_eff = clamp_size(int'(cfg_rows), ROWS_MAX);
		above = line_buf[scan_col % LINE_MAX];
		if (scan_row >= 1 && scan_col >= 1) begin
			w.pix  = morph_window(cfg_erode, upper_left, above, lower_left, px);
			w.last = (scan_col == cols_eff - 1 && scan_row == rows_eff - 1);
			pending_windows.push_back(w);
		end
		line_buf[scan_col % LINE_MAX] = px;
		if (scan_col + 1 > line_filled) line_filled = scan_col + 1;
		upper_left = above;
		lower_left = px;
		if (scan_col + 1 >= cols_eff) begin
			scan_col = 0;
			scan_row = (scan_row + 1 >= rows_eff) ? 0 : scan_row + 1;
		end else begin
			scan_col++;
		end
	endfunction

	function automatic bm2_pkg::pixel_t draw_pixel(input pixel_style_t style);
		int r;
		r = $urandom_range(9);
		case (style)
			STYLE_BINARY: begin
				return r[0] ? bm2_pkg::PIX_HIGH : bm2_pkg::PIX_LOW;
			end
			STYLE_MOSTLY_HIGH: begin
				if (r < 7) return bm2_pkg::PIX_HIGH;
				if (r == 7) return bm2_pkg::PIX_LOW;
				if (r == 8) return bm2_pkg::PIX_HIGH - 8'd1;
				return bm2_pkg::pixel_t'($urandom_range(255));
			end
			STYLE_MOSTLY_LOW: begin
				if (r < 7) return bm2_pkg::PIX_LOW;
				if (r == 7) return bm2_pkg::PIX_HIGH;
				if (r == 8) return bm2_pkg::PIX_LOW + 8'd1;
				return bm2_pkg::pixel_t'($urandom_range(255));
			end
			default: begin
				return bm2_pkg::pixel_t'($urandom_range(255));
			end
		endcase
	endfunction

	function automatic void note_fault(input string what);
		fault_count++;
		if (fault_count <= 10) $display("%0t: %s", $time, what);
	endfunction

	// Offer one item, idling first at the current rate, and hold it until taken
	task automatic send_pixel(input bm2_pkg::pixel_t value);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid    <= 1'b1;
		pix_ch.pixel_in <= value;
		@(posedge clk);
		while (!pix_ch.ready) @(posedge clk);
		step_raster_window(value);
		pixels_sent++;
	endtask

	task automatic wait_idle();
		pix_ch.valid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic erode, input logic [bm2_pkg::CFG_W-1:0] cols,
			input logic [bm2_pkg::CFG_W-1:0] rows);
		wait_idle();
		cfg_we    <= 1'b1;
		cfg_index <= bm2_pkg::REG_MODE;
		cfg_data  <= {{(bm2_pkg::CFG_W-1){1'b0}}, erode};
		@(posedge clk);
		cfg_index <= bm2_pkg::REG_COLS;
		cfg_data  <= cols;
		@(posedge clk);
		cfg_index <= bm2_pkg::REG_ROWS;
		cfg_data  <= rows;
		@(posedge clk);
		cfg_we    <= 1'b0;
		cfg_erode = erode;
		cfg_cols  = cols;
		cfg_rows  = rows;
	endtask

	// Complete whatever image the counters are part-way through
	task automatic finish_image(input pixel_style_t style);
		while (scan_col != 0 || scan_row != 0) send_pixel(draw_pixel(style));
	endtask

	task automatic test_dilate_directed();
		bm2_pkg::pixel_t img [9];
		img = '{8'd255, 8'd0, 8'd128, 8'd1, 8'd254, 8'd0, 8'd0, 8'd0, 8'd255};
		configure(bm2_pkg::MODE_DILATE, 11'd3, 11'd3);
		foreach (img[i]) send_pixel(img[i]);
	endtask

	// Sizes below the minimum clamp to a 2x2 image: one window each
	task automatic test_erode_directed();
		bm2_pkg::pixel_t img [8];
		img = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd1, 8'd254, 8'd0};
		configure(bm2_pkg::MODE_ERODE, 11'd1, 11'd0);
		foreach (img[i]) send_pixel(img[i]);
	endtask

	task automatic test_mid_image_changes();
		bm2_pkg::pixel_t head [6];
		bm2_pkg::pixel_t tail [3];
		head = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd254};
		tail = '{8'd255, 8'd1, 8'd255};
		configure(bm2_pkg::MODE_DILATE, 11'd4, 11'd3);
		foreach (head[i]) send_pixel(head[i]);
		configure(bm2_pkg::MODE_ERODE, 11'd4, 11'd3);
		send_pixel(8'd255);
		// column counter now beyond the new width: wrap after the next pixel
		configure(bm2_pkg::MODE_ERODE, 11'd2, 11'd3);
		foreach (tail[i]) send_pixel(tail[i]);
		finish_image(STYLE_BINARY);
	endtask

	task automatic test_size_extremes();
		// widest row: a full first row and part of the next, then shrink the width
		configure(bm2_pkg::MODE_DILATE, 11'd2047, 11'd2);
		repeat (1024 + 12) send_pixel(draw_pixel(STYLE_MOSTLY_LOW));
		configure(bm2_pkg::MODE_DILATE, 11'd6, 11'd2);
		finish_image(STYLE_MOSTLY_LOW);
		// tallest image: two dozen rows and one pixel, then shrink the height
		configure(bm2_pkg::MODE_ERODE, 11'd0, 11'd2047);
		repeat (2 * 24 + 1) send_pixel(draw_pixel(STYLE_MOSTLY_HIGH));
		configure(bm2_pkg::MODE_ERODE, 11'd0, 11'd3);
		finish_image(STYLE_MOSTLY_HIGH);
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure(bm2_pkg::MODE_DILATE, 11'd16, 11'd8);
		hold_len = 300;
		hold_seq++;
		repeat (16 * 8) send_pixel(draw_pixel(STYLE_BINARY));
	endtask

	task automatic test_random_images(input int n_pixels, input int send_pct, input int recv_pct);
		int                        target;
		int                        cut;
		int                        wide;
		logic                      erode;
		logic [bm2_pkg::CFG_W-1:0] cols;
		logic [bm2_pkg::CFG_W-1:0] rows;
		pixel_style_t              style;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		target = pixels_sent + n_pixels;
		while (pixels_sent < target) begin
			erode = 1'($urandom_range(1));
			cols  = ($urandom_range(7) == 0) ? bm2_pkg::CFG_W'($urandom_range(17, 48))
				: bm2_pkg::CFG_W'($urandom_range(0, 16));
			rows  = bm2_pkg::CFG_W'($urandom_range(0, 8));
			style = pixel_style_t'($urandom_range(3));
			configure(erode, cols, rows);
			if ($urandom_range(7) == 0) begin
				// broken image: change a setting part-way, then run out the raster
				cut = $urandom_range(1, clamp_size(int'(cols), LINE_MAX)
					* clamp_size(int'(rows), ROWS_MAX) - 1);
				repeat (cut) send_pixel(draw_pixel(style));
				erode = cfg_erode;
				cols  = cfg_cols;
				rows  = cfg_rows;
				wide  = (line_filled < 24) ? line_filled : 24;
				case ($urandom_range(2))
					0: begin
						erode = ~cfg_erode;
					end
					1: begin
						cols = bm2_pkg::CFG_W'($urandom_range(2, wide));
					end
					default: begin
						rows = bm2_pkg::CFG_W'($urandom_range(2, 8));
					end
				endcase
				configure(erode, cols, rows);
				finish_image(style);
			end else begin
				repeat (clamp_size(int'(cols), LINE_MAX) * clamp_size(int'(rows), ROWS_MAX))
					send_pixel(draw_pixel(style));
			end
		end
	endtask

	// Result side: random stalls, plus a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		window_res_t w;
		if (pix_ch.valid && !pix_ch.ready) stall_cycles++;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready) begin
			if (pending_windows.size() == 0) begin
				note_fault($sformatf("unexpected result: pixel %0d last %0b",
					res_ch.pixel_out, res_ch.last_out));
			end else begin
				w = pending_windows.pop_front();
				windows_checked++;
				if (w.last) image_ends++;
				if (res_ch.pixel_out !== w.pix || res_ch.last_out !== w.last)
					note_fault($sformatf(
						"result %0d: expected pixel %0d last %0b, got pixel %0d last %0b",
						windows_checked, w.pix, w.last, res_ch.pixel_out,
						res_ch.last_out));
			end
		end
	end

	initial begin
		arst_n          = 1'b0;
		cfg_we          = 1'b0;
		cfg_index       = bm2_pkg::REG_MODE;
		cfg_data        = '0;
		pix_ch.valid    = 1'b0;
		pix_ch.pixel_in = '0;
		res_ch.ready    = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// slow sender against a slower receiver first
		send_idle_pct = 31;
		recv_idle_pct = 88;
		test_dilate_directed();
		test_erode_directed();
		test_mid_image_changes();
		test_size_extremes();
		test_random_images(100, 31, 88);
		test_random_images(100, 88, 31);
		test_backpressure();
		test_random_images(100, 0, 0);

		wait_idle();
		repeat (8) @(posedge clk);
		$display("Sent %0d pixels: hand-made images, clamped and extreme sizes,",
			pixels_sent);
		$display("  mid-image changes, a long hold-off and random images; %0d windows, %0d ends",
			windows_checked, image_ends);
		$display("Input stalled for %0d cycles", stall_cycles);
		if (fault_count == 0 && pending_windows.size() == 0) begin
			$display("tb_binary_morphology_2x2 passed");
		end else begin
			$display("%0d faults, %0d results outstanding", fault_count, pending_windows.size());
			$display("tb_binary_morphology_2x2 failed");
		end
		$finish;
	end

endmodule

// File: filelist.f
src/bm2_pkg.sv
src/bm2_pix_if.sv
src/bm2_res_if.sv
src/bm2_line_buf.sv
src/bm2_scan.sv
src/bm2_window.sv
src/binary_morphology_2x2.sv
tb/tb_binary_morphology_2x2.sv
